[sv/wmfc_pkg.sv]
// ----------------------------------------------------------------------------
// wmfc_pkg
// Shared types and constants of the five-channel windowed mean block.
// ----------------------------------------------------------------------------
package wmfc_pkg;

    localparam int NCH       = 5;
    localparam int CH_W      = 16;
    localparam int CFG_W     = 9;
    localparam int CNT_OUT_W = 9;
    localparam int IN_W      = NCH * CH_W;
    localparam int OUT_RAW_W = NCH * CH_W + CNT_OUT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic [NCH-1:0][CH_W-1:0] t_chan_vec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic rd;
        logic upd;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

[sv/windowed_mean_five_channel.sv]
// ----------------------------------------------------------------------------
// windowed_mean_five_channel
// Moving average over the most recent window_len five-channel telemetry
// samples, one mean per channel plus the number of samples averaged.
//
//   Channel   Dir  Width  Contents
//   s_axis    in   80     one sample of five signed 16-bit channels
//   m_axis    out  96     five signed 16-bit means and the held count
//   cfg       in   9      window_len, write only
//
// An accepted beat passes the read, update and divider load states, SW serial
// division steps, SW being the running-sum width 16 + clog2(MAX_WINDOW), and
// the output state; a new beat is taken only after the last one leaves it.
// Reset is synchronous and active low and empties the ring; its memory is never cleared.
// A stalled result holds in its register while the next beat is processed;
// only the hand-off of that next result waits for m_axis_tready.
// ----------------------------------------------------------------------------
module windowed_mean_five_channel
    import wmfc_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Window length register.
    input  logic             i_cfg_wen,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // Sample input.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0 up: temperature [15:0], drive_pct [31:16],
    // drive_volt [47:32], drive_amp [63:48], speed [79:64].
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Result output.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // Fields from bit 0 up: mean_temperature [15:0], mean_drive_pct
    // [31:16], mean_drive_volt [47:32], mean_drive_amp [63:48],
    // mean_speed [79:64], held_count [88:80], zero padding [95:89].
    output logic [OUT_W-1:0] m_axis_tdata
);

    // Count width must hold MAX_WINDOW itself; sums grow by clog2 of it.
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = CH_W + $clog2(MAX_WINDOW);

    t_cmd w_cmd;

    // The controller walks each sample through read, update, divide and
    // output; it never overlaps two samples.
    wmfc_ctrl #(
        .STEPS (SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the ring, the running sums and the divider lanes.
    // The oldest sample is registered in the read state, and the update state subtracts it once the ring is full.
    wmfc_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW),
        .SW         (SW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .o_result    (m_axis_tdata)
    );

endmodule

[sv/wmfc_div.sv]
// ----------------------------------------------------------------------------
// wmfc_div
// One-bit-per-cycle restoring divider for one channel: signed sum divided
// by the held count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wmfc_div
    import wmfc_pkg::*;
#(
    parameter int SW = 24,
    parameter int CW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic signed [SW-1:0] i_sum,
    input  logic [CW-1:0]        i_div,
    output logic [CH_W-1:0]      o_mean
);

    logic          r_neg;
    logic [SW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_d;
    logic [CW:0]   w_trial;
    logic          w_fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_quo[SW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_sum[SW-1];
            r_quo <= i_sum[SW-1] ? (-i_sum) : i_sum;
            r_rem <= '0;
            r_d   <= i_div;
        end else if (i_step) begin
            if (w_fits) begin
                r_rem <= CW'(w_trial - {1'b0, r_d});
            end else begin
                r_rem <= CW'(w_trial);
            end
            r_quo <= {r_quo[SW-2:0], w_fits};
        end
    end

    // The magnitude of a mean never exceeds 32768, so 16 bits carry it.
    assign o_mean = r_neg ? (-CH_W'(r_quo)) : CH_W'(r_quo);

endmodule

[sv/wmfc_dpath.sv]
// ----------------------------------------------------------------------------
// wmfc_dpath
// Datapath: sample ring memory, running channel sums, fill and slot
// bookkeeping, five divider lanes and the result register.
// ----------------------------------------------------------------------------
module wmfc_dpath
    import wmfc_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int CW         = 9,
    parameter int SW         = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_wen,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]  i_sample,
    output logic [OUT_W-1:0] o_result
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RST_WIN = (MAX_WINDOW < 256) ? MAX_WINDOW : 256;
    localparam logic [31:0] MaxWin32 = 32'(MAX_WINDOW);

    logic [IN_W-1:0]        ring [MAX_WINDOW];
    t_chan_vec              r_samp;
    t_chan_vec              r_old;
    logic signed [SW-1:0]   r_sum [NCH];
    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          r_window;
    logic [AW-1:0]          r_wslot;
    logic [OUT_W-1:0]       r_out;
    logic                   w_filling;
    logic [AW-1:0]          w_slot;
    logic [CW-1:0]          w_wslot_inc;
    logic [NCH-1:0][CH_W-1:0] w_mean;

    assign w_filling   = (r_fill < r_window);
    assign w_slot      = w_filling ? r_fill[AW-1:0] : r_wslot;
    assign w_wslot_inc = CW'(r_wslot) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_samp <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_old <= ring[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            ring[w_slot] <= r_samp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wslot  <= '0;
            r_window <= CW'(RST_WIN);
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_cfg_wen) begin
            // Any window write empties the ring.
            r_fill  <= '0;
            r_wslot <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
            if (i_cfg_wdata == '0) begin
                r_window <= CW'(1);
            end else if (32'(i_cfg_wdata) > MaxWin32) begin
                r_window <= CW'(MAX_WINDOW);
            end else begin
                r_window <= CW'(i_cfg_wdata);
            end
        end else if (i_cmd.upd) begin
            for (int c = 0; c < NCH; c++) begin
                if (w_filling) begin
                    r_sum[c] <= r_sum[c] + SW'($signed(r_samp[c]));
                end else begin
                    r_sum[c] <= r_sum[c] + SW'($signed(r_samp[c]))
                                - SW'($signed(r_old[c]));
                end
            end
            if (w_filling) begin
                r_fill <= r_fill + CW'(1);
            end else if (w_wslot_inc >= r_window) begin
                r_wslot <= '0;
            end else begin
                r_wslot <= AW'(w_wslot_inc);
            end
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_lane
        wmfc_div #(
            .SW (SW),
            .CW (CW)
        ) u_div (
            .i_clk  (i_clk),
            .i_load (i_cmd.div_load),
            .i_step (i_cmd.div_step),
            .i_sum  (r_sum[g]),
            .i_div  (r_fill),
            .o_mean (w_mean[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= OUT_W'({CNT_OUT_W'(r_fill), w_mean});
        end
    end

    assign o_result = r_out;

endmodule

[sv/wmfc_ctrl.sv]
// ----------------------------------------------------------------------------
// wmfc_ctrl
// Controller: sequences read, update, division and result hand-off for one
// sample at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module wmfc_ctrl
    import wmfc_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam int CNTW = $clog2(STEPS);

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_DLOAD;
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/wmfc_chk.sv]
// ----------------------------------------------------------------------------
// wmfc_chk
// Port-level checker for the windowed mean block, bound to the top level.
// ----------------------------------------------------------------------------
module wmfc_chk
    import wmfc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_wen,
    input logic [CFG_W-1:0] i_cfg_wdata,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // A result once offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped before it was taken");

    // One sample at a time: the input stays closed through the read, update and divider load states.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready
        ##1 !s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // Every result averages at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[88:80] != '0)
        else $error("result carries a held count of zero");

    // The padding above the held count is always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:89] == '0)
        else $error("result padding bits are not zero");

endmodule

bind windowed_mean_five_channel wmfc_chk u_wmfc_chk (.*);

[dv/windowed_mean_five_channel_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_mean_five_channel_tb
// Self-checking bench for the five-channel moving average. Samples go in on
// the slave stream and means come back on the master stream. A scoreboard
// keeps its own ring, running sums and window length, and works out the
// expected means for every accepted sample. Each returned beat is checked
// field by field against the oldest expectation. The window register is
// rewritten between phases, including the out-of-range values, and both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module windowed_mean_five_channel_tb
    import wmfc_pkg::*;
();

    localparam int WIN_MAX       = 256;
    // This margin covers one sample still in flight through the
    // block.
    localparam int SETTLE_CYCLES = 32;
    // The receiver stops for this long once, so that the result register
    // and then the input side back up.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 150;
    // Beat counts between which neither side idles.
    localparam int CALM_FIRST    = 700;
    localparam int CALM_LAST     = 850;

    // One result beat as the scoreboard expects it.
    typedef struct packed {
        logic [CNT_OUT_W-1:0] held;
        t_chan_vec            means;
    } t_mean_beat;

    // Tracks the window contents and predicts the means of every sample.
    class channel_mean_tracker;
        shortint    ring [WIN_MAX][NCH];
        int         fill;
        int         slot;
        int         sums [NCH];
        int         win;
        int         errors;
        int         n_checked;
        t_mean_beat pending_means [$];
        string      ch_names [NCH] = '{"mean_temperature", "mean_drive_pct",
                                       "mean_drive_volt", "mean_drive_amp",
                                       "mean_speed"};

        function new();
            win       = WIN_MAX;
            errors    = 0;
            n_checked = 0;
            empty_window();
        endfunction

        function void empty_window();
            fill = 0;
            slot = 0;
            foreach (sums[c]) sums[c] = 0;
        endfunction

        // A zero acts as one and anything above the store depth as the depth.
        // Every write also throws away the samples held so far.
        function void set_window(logic [CFG_W-1:0] value);
            if (value == 0) begin
                win = 1;
            end else if (value > WIN_MAX) begin
                win = WIN_MAX;
            end else begin
                win = value;
            end
            empty_window();
        endfunction

        function void take_sample(t_chan_vec smp);
            t_mean_beat exp_beat;
            int         idx;
            if (fill < win) begin
                idx = fill;
                fill++;
            end else begin
                // Ring full: the oldest sample leaves the sums.
                idx = slot;
                foreach (sums[c]) sums[c] -= ring[idx][c];
                slot = (slot + 1 >= win) ? 0 : slot + 1;
            end
            for (int c = 0; c < NCH; c++) begin
                ring[idx][c] = shortint'(smp[c]);
                sums[c] += ring[idx][c];
                // Integer division of signed ints truncates toward zero.
                exp_beat.means[c] = 16'(sums[c] / fill);
            end
            exp_beat.held = CNT_OUT_W'(fill);
            pending_means.insert(pending_means.size(), exp_beat);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        function void check_means(logic [OUT_W-1:0] beat);
            t_mean_beat exp_beat;
            t_chan_vec  got_means;
            logic [CNT_OUT_W-1:0] got_held;
            n_checked++;
            if (pending_means.size() == 0) begin
                note_error($sformatf("result beat %0d arrived with nothing expected: %h",
                                     n_checked, beat));
                return;
            end
            exp_beat  = pending_means.pop_front();
            got_means = beat[IN_W-1:0];
            got_held  = beat[IN_W +: CNT_OUT_W];
            for (int c = 0; c < NCH; c++) begin
                if (got_means[c] !== exp_beat.means[c]) begin
                    note_error($sformatf("beat %0d %s: expected %0d, got %0d", n_checked,
                                         ch_names[c], $signed(exp_beat.means[c]),
                                         $signed(got_means[c])));
                end
            end
            if (got_held !== exp_beat.held) begin
                note_error($sformatf("beat %0d held_count: expected %0d, got %0d",
                                     n_checked, exp_beat.held, got_held));
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wen;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // Fields from bit 0 up: temperature, drive_pct, drive_volt,
    // drive_amp, speed.
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // Fields from bit 0 up: mean_temperature, mean_drive_pct,
    // mean_drive_volt, mean_drive_amp, mean_speed, held_count.
    logic [OUT_W-1:0] m_axis_tdata;

    channel_mean_tracker tracker = new();

    int n_sent    = 0;
    int n_recv    = 0;
    int n_windows = 0;

    windowed_mean_five_channel #(
        .MAX_WINDOW (WIN_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Both sides idle about a third of the time, except inside the calm
    // stretch where every cycle carries a beat if the block allows it.
    function automatic bit idle_now(int beat_count);
        if (beat_count >= CALM_FIRST && beat_count < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < 34;
    endfunction

    // Channel values lean on the extremes and on small numbers around zero,
    // where truncation of negative means shows. A bias of 1 favors the
    // largest value and 2 the smallest, to drive the running sums to their
    // limits over a full ring.
    function automatic logic [CH_W-1:0] rand_channel(int bias);
        if (bias == 1 && $urandom_range(3) != 0) begin
            return 16'h7FFF;
        end
        if (bias == 2 && $urandom_range(3) != 0) begin
            return 16'h8000;
        end
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'(int'($urandom_range(6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one sample, idling first at random, and returns on the edge
    // that accepts it. Valid stays high so back-to-back beats need no gap.
    task automatic send_sample(input t_chan_vec smp);
        while (idle_now(n_sent)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        tracker.take_sample(smp);
        n_sent++;
    endtask

    task automatic send_random(input int count, input int bias);
        t_chan_vec smp;
        repeat (count) begin
            for (int c = 0; c < NCH; c++) smp[c] = rand_channel(bias);
            send_sample(smp);
        end
    endtask

    // Stops offering and waits until every expected mean has come back,
    // then gives the block time to finish anything still in flight.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written with the block idle. The write empties
    // the ring on both sides.
    task automatic change_window(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        tracker.set_window(value);
        n_windows++;
    endtask

    // Result side: random stalls, one long hold-off, and a check of every
    // beat taken.
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held_off && n_recv == HOLD_AT) begin
                // The sender keeps offering through this stretch, so the
                // block has to hold its result and then refuse samples.
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
            end else if (idle_now(n_recv)) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                if (m_axis_tvalid === 1'b1) begin
                    tracker.check_means(m_axis_tdata);
                    n_recv++;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset window of full depth.
        send_sample({NCH{16'h0000}});
        send_sample({NCH{16'h7FFF}});
        send_sample({NCH{16'h7FFF}});
        send_sample({NCH{16'h8000}});
        send_sample({NCH{16'h8000}});
        send_sample({NCH{16'hFFFF}});
        send_sample({NCH{16'h0001}});
        send_sample('{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
        send_sample({NCH{16'h5555}});
        send_sample({NCH{16'hAAAA}});

        // A window of zero behaves as a window of one.
        change_window(CFG_W'(0));
        send_sample({NCH{16'h8000}});
        send_sample({NCH{16'h7FFF}});
        send_sample({NCH{16'hFFFD}});

        // Window of two: the ring wraps at once, and odd negative sums
        // must truncate toward zero.
        change_window(CFG_W'(2));
        send_sample({NCH{16'hFFFF}});
        send_sample({NCH{16'hFFFE}});
        send_sample({NCH{16'h0003}});
        send_sample('{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'hFFFB});

        // All-ones write, above the store depth, clamps to full depth.
        change_window(CFG_W'(511));
        send_sample({NCH{16'h8000}});
        send_sample({NCH{16'h7FFF}});

        // Random part. The two biased full-depth phases run past the ring size so
        // the oldest sample gets replaced, with the sums pushed toward
        // their largest and smallest values.
        change_window(CFG_W'(WIN_MAX));
        send_random(290, 1);
        change_window(CFG_W'(WIN_MAX + 1));
        send_random(40, 0);
        change_window(CFG_W'(1));
        send_random(30, 0);
        change_window(CFG_W'(0));
        send_random(40, 0);
        change_window(CFG_W'(2));
        send_random(50, 0);
        change_window(CFG_W'(3));
        send_random(60, 0);
        change_window(CFG_W'(511));
        send_random(280, 2);
        repeat (4) begin
            change_window(CFG_W'($urandom_range(4, 120)));
            send_random(100, 0);
        end

        wait_drained();
        $display("Covered %0d samples and %0d result beats over %0d window writes, %0d errors.",
                 n_sent, tracker.n_checked, n_windows, tracker.errors);
        $display("Windows of zero, one, two, full depth and above it, with ring wrap-around.");
        if (tracker.errors == 0 && tracker.pending_means.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hang; a correct run needs well under a tenth of this.
    initial begin : watchdog
        #10_000_000;
        $display("Timeout with %0d results still expected.", tracker.pending_means.size());
        $display("FAIL");
        $finish;
    end

endmodule

[windowed_mean_five_channel.f]
sv/wmfc_pkg.sv
sv/wmfc_div.sv
sv/wmfc_dpath.sv
sv/wmfc_ctrl.sv
sv/windowed_mean_five_channel.sv
sv/wmfc_chk.sv
dv/windowed_mean_five_channel_tb.sv
